// ===== rtl/core/policy_ordered_job_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the policy ordered job queue
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef POLICY_ORDERED_JOB_QUEUE_MACROS_SVH
`define POLICY_ORDERED_JOB_QUEUE_MACROS_SVH

// Checked at every rising edge while reset is released.
`define POJQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also while reset is held.
`define POJQ_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pojq_pkg.sv =====
// ----------------------------------------------------------------------------
// Policy ordered job queue package
// Sizes, codes and the types that travel along the chain of queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pojq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 4;
    localparam int KEY_W       = 16;
    localparam int WAIT_W      = 21;
    localparam int QCNT_W      = 5;
    localparam int QCNT_MAX    = 31;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // Operation codes.
    localparam logic [1:0] OP_SUBMIT   = 2'd0;
    localparam logic [1:0] OP_DISPATCH = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Order policies.
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Candidate and running sum handed from one cell to the next.
    typedef struct packed {
        logic [WAIT_W-1:0] sum;
        logic              has;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  idx;
        entry_t            job;
    } link_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [1:0]       policy;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
        logic             shift_en;
        logic [IDX_W-1:0] shift_idx;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/policy_ordered_job_queue.sv =====
// ----------------------------------------------------------------------------
// Policy ordered job queue
// Pending job queue with first come, shortest burst or priority dispatch.
// ----------------------------------------------------------------------------
// Every item (submit, dispatch or complete) is taken in the idle state. The
// scan state then runs the row of queue cells, and the apply state registers
// the result beat. The block takes one item at a time: the next item can be
// accepted once the state is back in idle, while the result is shown on the
// output. A result that still waits on the output holds the apply step, and
// with it the next input. In the scan, the running wait sum and the best
// candidate move one cell per cycle from the oldest to the youngest job;
// then the apply step stores, shifts or clears.
// Ties in the order key go to the oldest job. Entries above the pending
// count are never read, so the queue needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module policy_ordered_job_queue
    import pojq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          operation,
    input  wire logic [TAG_W-1:0]    job_tag,
    input  wire logic [BURST_W-1:0]  burst_time,
    input  wire logic [PRIO_W-1:0]   job_priority,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               status,
    output logic [TAG_W-1:0]         out_tag,
    output logic [BURST_W-1:0]       out_burst,
    output logic [PRIO_W-1:0]        out_priority,
    output logic [WAIT_W-1:0]        expected_wait,
    output logic [QCNT_W-1:0]        queued_jobs
);

    state_t               state_reg;
    state_t               state_next;
    logic [IDX_W-1:0]     scan_cnt_reg;
    logic [IDX_W-1:0]     scan_cnt_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [BURST_W-1:0]   run_burst_reg;
    logic [BURST_W-1:0]   run_burst_next;
    logic [1:0]           policy_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [1:0]           op_reg;
    entry_t               item_reg;

    logic [1:0]           status_reg;
    entry_t               res_job_reg;
    logic [WAIT_W-1:0]    wait_reg;
    logic [QCNT_W-1:0]    qcnt_reg;

    logic                 accept;
    logic                 commit;
    logic                 cfg_write;

    logic [1:0]           res_status;
    entry_t               res_job;
    logic [WAIT_W-1:0]    res_wait;
    logic [CNT_W-1:0]     res_count;
    logic [BURST_W-1:0]   res_run_burst;
    logic                 res_wr;
    logic                 res_shift;

    cell_ctl_t            ctl;
    link_t                links [0:QUEUE_DEPTH];
    entry_t               entries [0:QUEUE_DEPTH-1];
    link_t                fin;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? 32'(policy_reg) : 32'd0;

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_SCAN:  in_stall = 1'b1;
            ST_APPLY: commit   = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    assign accept = in_valid && !in_stall;

    assign fin = links[QUEUE_DEPTH];

    // Result and state update once the chain has settled.
    always_comb
    begin
        res_status    = STAT_DONE;
        res_job       = '0;
        res_wait      = '0;
        res_count     = count_reg;
        res_run_burst = run_burst_reg;
        res_wr        = 1'b0;
        res_shift     = 1'b0;
        case (op_reg)
            OP_SUBMIT:
            begin
                if (32'(count_reg) >= QUEUE_DEPTH)
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    res_wait  = fin.sum;
                    res_wr    = 1'b1;
                    res_count = count_reg + 1'b1;
                end
            end
            OP_DISPATCH:
            begin
                if (count_reg == '0)
                begin
                    res_status = STAT_EMPTY;
                end
                else
                begin
                    res_job       = fin.job;
                    res_shift     = 1'b1;
                    res_count     = count_reg - 1'b1;
                    res_run_burst = fin.job.burst;
                end
            end
            OP_COMPLETE:
            begin
                res_run_burst = '0;
            end
            default:
            begin
                res_status = STAT_DONE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        run_burst_next = run_burst_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (commit)
        begin
            count_next     = res_count;
            run_burst_next = res_run_burst;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            run_burst_reg <= '0;
            policy_reg    <= POL_FCFS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            run_burst_reg <= run_burst_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (paddr[2] == 1'b0))
            begin
                policy_reg <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= operation;
            item_reg.tag   <= job_tag;
            item_reg.burst <= burst_time;
            item_reg.prio  <= job_priority;
        end
        if (commit)
        begin
            status_reg  <= res_status;
            res_job_reg <= res_job;
            wait_reg    <= res_wait;
            qcnt_reg    <= (32'(res_count) > QCNT_MAX) ? QCNT_W'(QCNT_MAX)
                                                       : QCNT_W'(res_count);
        end
    end

    // Head of the chain: the running burst starts the sum, no candidate yet.
    always_comb
    begin
        links[0]     = '0;
        links[0].sum = WAIT_W'(run_burst_reg);
    end

    always_comb
    begin
        ctl.count     = count_reg;
        ctl.policy    = policy_reg;
        ctl.wr_en     = commit && res_wr;
        ctl.wr_idx    = IDX_W'(count_reg);
        ctl.wr_data   = item_reg;
        ctl.shift_en  = commit && res_shift;
        ctl.shift_idx = fin.idx;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t neighbor;

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign neighbor = entries[g];
        end
        else
        begin : g_mid
            assign neighbor = entries[g + 1];
        end

        pojq_cell u_cell (
            .clk        (clk),
            .cell_index (IDX_W'(g)),
            .ctl        (ctl),
            .link_in    (links[g]),
            .next_entry (neighbor),
            .link_out   (links[g + 1]),
            .entry      (entries[g])
        );
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_tag       = res_job_reg.tag;
    assign out_burst     = res_job_reg.burst;
    assign out_priority  = res_job_reg.prio;
    assign expected_wait = wait_reg;
    assign queued_jobs   = qcnt_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pojq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one pending job and one stage of the compare and sum chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pojq_cell
    import pojq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] cell_index,
    input  wire cell_ctl_t        ctl,
    input  wire link_t            link_in,
    input  wire entry_t           next_entry,
    output link_t                 link_out,
    output entry_t                entry
);

    entry_t              entry_reg;
    entry_t              entry_next;
    link_t               link_reg;
    link_t               link_next;
    logic                active;
    logic                take;
    logic [KEY_W-1:0]    own_key;
    logic [WAIT_W:0]     sum_ext;

    assign active = CNT_W'(cell_index) < ctl.count;

    always_comb
    begin
        case (ctl.policy)
            POL_SJF:  own_key = KEY_W'(entry_reg.burst);
            POL_PRIO: own_key = KEY_W'(entry_reg.prio);
            default:  own_key = '0;
        endcase
    end

    // Strict less keeps the older job on a tie.
    assign take    = active && (!link_in.has || (own_key < link_in.key));
    assign sum_ext = {1'b0, link_in.sum} + (WAIT_W + 1)'(entry_reg.burst);

    always_comb
    begin
        link_next = link_in;
        if (active)
        begin
            link_next.sum = sum_ext[WAIT_W] ? WAIT_MAX : sum_ext[WAIT_W-1:0];
        end
        if (take)
        begin
            link_next.has = 1'b1;
            link_next.key = own_key;
            link_next.idx = cell_index;
            link_next.job = entry_reg;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.wr_en && (ctl.wr_idx == cell_index))
        begin
            entry_next = ctl.wr_data;
        end
        else if (ctl.shift_en && (cell_index >= ctl.shift_idx))
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        link_reg  <= link_next;
    end

    assign link_out = link_reg;
    assign entry    = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pojq_checker.sv =====
// ----------------------------------------------------------------------------
// Policy ordered job queue checker
// Port level checks on result beats and input acceptance, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "policy_ordered_job_queue_macros.svh"

module pojq_checker
    import pojq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [1:0]          status,
    input  wire logic [TAG_W-1:0]    out_tag,
    input  wire logic [BURST_W-1:0]  out_burst,
    input  wire logic [PRIO_W-1:0]   out_priority,
    input  wire logic [WAIT_W-1:0]   expected_wait,
    input  wire logic [QCNT_W-1:0]   queued_jobs
);

    logic                                          in_beat;
    logic                                          out_held;
    logic                                          full_beat;
    logic                                          empty_beat;
    logic                                          count_full;
    logic                                          empty_clean;
    logic                                          count_in_range;
    logic [1+TAG_W+BURST_W+PRIO_W+WAIT_W+QCNT_W:0] out_payload;

    assign in_beat        = in_valid && !in_stall;
    assign out_held       = out_valid && out_stall;
    assign out_payload    = {status, out_tag, out_burst, out_priority, expected_wait,
                             queued_jobs};
    assign full_beat      = out_valid && (status == STAT_FULL);
    assign empty_beat     = out_valid && (status == STAT_EMPTY);
    assign count_full     = (32'(queued_jobs) == QUEUE_DEPTH) ||
                            (32'(queued_jobs) == QCNT_MAX);
    assign empty_clean    = (queued_jobs == '0) && (out_tag == '0) && (out_burst == '0) &&
                            (out_priority == '0);
    assign count_in_range = 32'(queued_jobs) <= QUEUE_DEPTH;

    // A stalled result beat stays and keeps its payload.
    `POJQ_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_payload), "held beat changed")

    // One item at a time: an accepted input beat stalls the port next cycle.
    `POJQ_ASSERT(a_one_item, in_beat |=> in_stall, "second item accepted during work")

    // A rejected submit reports a full queue.
    `POJQ_ASSERT(a_full_count, full_beat |-> count_full, "full status with room in the queue")

    // An empty dispatch reports no job and an empty queue.
    `POJQ_ASSERT(a_empty_job, empty_beat |-> empty_clean, "empty status with a job")

    // The pending count never passes the queue depth.
    `POJQ_ASSERT(a_depth, out_valid |-> count_in_range, "pending count beyond queue depth")

endmodule

bind policy_ordered_job_queue pojq_checker u_pojq_checker (.*);

`default_nettype wire
